// ===== hw/rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps

package utf8d_pkg;

   localparam int unsigned CP_W      = 21;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CMD_DEPTH = 4;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_TWO        = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE      = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR       = 21'h010000;

   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
   localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
   localparam logic [BYTE_W-1:0] DATA_MASK  = 8'h3F;

   // One work unit for the back end: a run of malformed replacements,
   // then optionally one well-formed code point.
   typedef struct packed {
      logic [2:0]      n_rep;
      logic            has_tail;
      logic [CP_W-1:0] tail_cp;
   } cmd_type;

   // Classification of a byte seen as a lead.
   typedef struct packed {
      logic            is_ascii;
      logic            invalid;
      logic [1:0]      need;
      logic [CP_W-1:0] init_acc;
   } lead_type;

   function automatic lead_type decode_lead(input logic [BYTE_W-1:0] b);
      lead_type l;
      l = '0;
      if (b < ASCII_LIM) begin
         l.is_ascii = 1'b1;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         l.need     = 2'd1;
         l.init_acc = CP_W'(b[4:0]);
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         l.need     = 2'd2;
         l.init_acc = CP_W'(b[3:0]);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         l.need     = 2'd3;
         l.init_acc = CP_W'(b[2:0]);
      end else begin
         l.invalid = 1'b1;
      end
      return l;
   endfunction

   function automatic logic value_rejected(input logic [CP_W-1:0] v, input logic [2:0] conts);
      logic r;
      r = 1'b0;
      if (v > MAX_CP) r = 1'b1;
      if (v >= SURR_LO && v <= SURR_HI) r = 1'b1;
      if (conts == 3'd1 && v < MIN_TWO) r = 1'b1;
      if (conts == 3'd2 && v < MIN_THREE) r = 1'b1;
      if (conts == 3'd3 && v < MIN_FOUR) r = 1'b1;
      return r;
   endfunction

endpackage

// ===== hw/rtl/utf8d_front.sv =====
`timescale 1ns / 1ps

module utf8d_front import utf8d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [BYTE_W-1:0] byte_in,
   output logic              cmd_push,
   output cmd_type           cmd
);

   logic [1:0]      needed_ff, needed_in;
   logic [1:0]      held_ff, held_in;
   logic [CP_W-1:0] acc_ff, acc_in;

   lead_type        lead;
   logic [2:0]      conts;
   logic [1:0]      need_dec;
   logic [CP_W-1:0] acc_shift;
   logic            is_cont;
   logic            use_lead;
   logic [2:0]      pre_rep;

   assign lead      = decode_lead(byte_in);
   assign is_cont   = (byte_in & CONT_MASK) == CONT_CODE;
   assign conts     = {1'b0, held_ff} + 3'd1;
   assign need_dec  = needed_ff - 2'd1;
   assign acc_shift = {acc_ff[CP_W-7:0], byte_in[5:0] & DATA_MASK[5:0]};

   // Classify the beat and work out the next sequence state
   always_comb begin
      needed_in = needed_ff;
      held_in   = held_ff;
      acc_in    = acc_ff;
      cmd       = '0;
      use_lead  = 1'b0;
      pre_rep   = 3'd0;
      if (needed_ff == 2'd0) begin
         use_lead = 1'b1;
      end else if (is_cont) begin
         needed_in = need_dec;
         if (need_dec == 2'd0) begin
            if (value_rejected(acc_shift, conts)) begin
               cmd.n_rep = conts + 3'd1;
            end else begin
               cmd.has_tail = 1'b1;
               cmd.tail_cp  = acc_shift;
            end
            held_in = 2'd0;
            acc_in  = '0;
         end else begin
            held_in = conts[1:0];
            acc_in  = acc_shift;
         end
      end else begin
         use_lead = 1'b1;
         pre_rep  = conts;
      end

      // Restart on this byte as a new lead
      if (use_lead) begin
         held_in   = 2'd0;
         acc_in    = lead.init_acc;
         needed_in = lead.need;
         cmd.n_rep = pre_rep + {2'd0, lead.invalid};
         if (lead.is_ascii) begin
            cmd.has_tail = 1'b1;
            cmd.tail_cp  = CP_W'(byte_in);
         end
      end
   end

   assign cmd_push = byte_valid && (cmd.has_tail || cmd.n_rep != 3'd0);

   // Advance sequence state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff <= 2'd0;
         held_ff   <= 2'd0;
         acc_ff    <= '0;
      end else if (byte_valid) begin
         needed_ff <= needed_in;
         held_ff   <= held_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

// ===== hw/rtl/utf8d_cmd_fifo.sv =====
`timescale 1ns / 1ps

module utf8d_cmd_fifo import utf8d_pkg::*; #(
   parameter int unsigned Depth = CMD_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign full    = count_ff == CntW'(Depth);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ===== hw/rtl/utf8d_back.sv =====
`timescale 1ns / 1ps

module utf8d_back import utf8d_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_empty,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   output logic            out_empty,
   input  logic            out_pop,
   output logic [CP_W-1:0] out_code_point,
   output logic            out_malformed,
   output logic            out_last
);

   logic [1:0]      idx_ff;
   logic            out_valid_ff;
   logic [CP_W-1:0] out_cp_ff;
   logic            out_bad_ff, out_last_ff;

   logic            slot_free, emit, is_rep, is_last;
   logic [2:0]      total;

   assign slot_free = !out_valid_ff || out_pop;
   assign emit      = !cmd_empty && slot_free;
   assign total     = cmd.n_rep + {2'd0, cmd.has_tail};
   assign is_rep    = {1'b0, idx_ff} < cmd.n_rep;
   assign is_last   = ({1'b0, idx_ff} + 3'd1) == total;
   assign cmd_pop   = emit && is_last;

   // Walk the results of the head command, one per cycle while the output register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (emit) idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
         if (emit) out_valid_ff <= 1'b1;
         else if (out_pop) out_valid_ff <= 1'b0;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_cp_ff   <= is_rep ? REPLACEMENT_CP : cmd.tail_cp;
         out_bad_ff  <= is_rep;
         out_last_ff <= is_last;
      end
   end

   assign out_empty      = !out_valid_ff;
   assign out_code_point = out_cp_ff;
   assign out_malformed  = out_bad_ff;
   assign out_last       = out_last_ff;

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                         Beat taken when
// input     req_push, req_full, req_byte_in               req_push && !req_full
// result    rsp_pop, rsp_empty, rsp_code_point,           rsp_pop && !rsp_empty
//           rsp_malformed, rsp_last_of_run
//
// The front end decodes one byte per cycle while req_full is low and queues a
// command for each byte that yields results; the back end emits one result per
// cycle, while its output register is free, from the command queue into it.
// req_full rises only when the CmdDepth-entry command queue is full.
// Synchronous active-high reset clears sequence state, queue and output valid.

module utf8_stream_decoder import utf8d_pkg::*; #(
   parameter int unsigned CmdDepth = CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [BYTE_W-1:0] req_byte_in,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_malformed,
   output logic              rsp_last_of_run
);

   logic    byte_valid, cmd_push, cmd_pop, cmd_empty;
   cmd_type cmd_new, cmd_head;

   assign byte_valid = req_push && !req_full;

   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_in    (req_byte_in),
      .cmd_push   (cmd_push),
      .cmd        (cmd_new)
   );

   utf8d_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   utf8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd            (cmd_head),
      .cmd_pop        (cmd_pop),
      .out_empty      (rsp_empty),
      .out_pop        (rsp_pop),
      .out_code_point (rsp_code_point),
      .out_malformed  (rsp_malformed),
      .out_last       (rsp_last_of_run)
   );

endmodule

// ===== bench/utf8_stream_decoder_test.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
   import utf8d_pkg::*;

   // One input beat; known rows carry their expected results typed in.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              known;
      logic [2:0]        n_res;
      logic [CP_W-1:0]   cp;
      logic              bad;
   } stim_row_type;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            bad;
      logic            last;
   } cp_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_malformed;
   logic              rsp_last_of_run;

   // Directed bytes: extremes, proper U+FFFD, U+10FFFF, and each malformed form.
   stim_row_type directed_rows [26] = '{
      '{8'h00, 1'b1, 3'd1, 21'h000000, 1'b0},  // NUL is plain data
      '{8'h7F, 1'b1, 3'd1, 21'h00007F, 1'b0},
      '{8'h80, 1'b1, 3'd1, REPLACEMENT_CP, 1'b1},  // stray continuation
      '{8'hFF, 1'b1, 3'd1, REPLACEMENT_CP, 1'b1},  // invalid lead
      '{8'hEF, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hBD, 1'b0, 3'd0, 21'h0, 1'b0},  // well-formed U+FFFD, not malformed
      '{8'hF4, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h8F, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 3'd0, 21'h0, 1'b0},  // top scalar value
      '{8'hC0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b1, 3'd2, REPLACEMENT_CP, 1'b1},  // overlong two-byte form
      '{8'hED, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hA0, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b1, 3'd3, REPLACEMENT_CP, 1'b1},  // surrogate
      '{8'hF4, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h90, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b1, 3'd4, REPLACEMENT_CP, 1'b1},  // above the scalar range
      '{8'hE2, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h82, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hC3, 1'b0, 3'd0, 21'h0, 1'b0},  // new lead breaks a held sequence
      '{8'hA9, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hC3, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h41, 1'b0, 3'd0, 21'h0, 1'b0}   // ASCII breaks a bare lead
   };

   stim_row_type  send_q [$];
   cp_result_type expected_q [$];
   cp_result_type byte_results [$];

   // Decoder state as the block should hold it.
   logic [1:0]      seq_need = '0;
   logic [1:0]      seq_held = '0;
   logic [CP_W-1:0] seq_acc  = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_active = 1'b0;
   int err_count = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int replacements_seen = 0;
   int full_cycles = 0;

   utf8_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_byte_in    (req_byte_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_code_point (rsp_code_point),
      .rsp_malformed  (rsp_malformed),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report(input string what);
      err_count++;
      if (err_count <= 40) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic emit(input logic [CP_W-1:0] cp, input logic bad);
      cp_result_type r;
      r.cp = cp;
      r.bad = bad;
      r.last = 1'b0;
      byte_results.push_back(r);
   endtask

   task automatic emit_replacements(input int count);
      for (int i = 0; i < count; i++) emit(REPLACEMENT_CP, 1'b1);
   endtask

   // Treat the byte as the start of something new.
   task automatic open_sequence(input logic [BYTE_W-1:0] b);
      seq_need = 2'd0;
      seq_held = 2'd0;
      seq_acc  = '0;
      if (!b[7]) begin
         emit(CP_W'(b), 1'b0);
      end else if (b[7:5] == 3'b110) begin
         seq_need = 2'd1;
         seq_acc  = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         seq_need = 2'd2;
         seq_acc  = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         seq_need = 2'd3;
         seq_acc  = CP_W'(b[2:0]);
      end else begin
         emit_replacements(1);
      end
   endtask

   // Work out the code points one byte causes and advance the decoder state.
   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      int   conts;
      logic reject;
      byte_results.delete();
      if (seq_need == 2'd0) begin
         open_sequence(b);
      end else if (b[7:6] == 2'b10) begin
         conts    = int'(seq_held) + 1;
         seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
         seq_need = seq_need - 2'd1;
         if (seq_need == 2'd0) begin
            reject = (seq_acc > MAX_CP) || (seq_acc >= SURR_LO && seq_acc <= SURR_HI)
                     || (conts == 1 && seq_acc < MIN_TWO)
                     || (conts == 2 && seq_acc < MIN_THREE)
                     || (conts == 3 && seq_acc < MIN_FOUR);
            if (reject) emit_replacements(conts + 1);
            else emit(seq_acc, 1'b0);
            seq_held = 2'd0;
            seq_acc  = '0;
         end else begin
            seq_held = 2'(conts);
         end
      end else begin
         emit_replacements(int'(seq_held) + 1);
         open_sequence(b);
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
   endtask

   function automatic stim_row_type data_row(input logic [BYTE_W-1:0] b);
      stim_row_type row;
      row = '0;
      row.data = b;
      return row;
   endfunction

   function automatic logic [CP_W-1:0] pick_scalar(input int len);
      logic [CP_W-1:0] v;
      case (len)
         2: v = CP_W'($urandom_range(MIN_TWO, MIN_THREE - 1));
         3: begin
            v = CP_W'($urandom_range(MIN_THREE, MIN_FOUR - 1));
            if (v >= SURR_LO && v <= SURR_HI) v = v ^ 21'h002000;
         end
         default: v = CP_W'($urandom_range(MIN_FOUR, MAX_CP));
      endcase
      return v;
   endfunction

   // Queue the first keep bytes of the len-byte form of cp.
   task automatic push_encoded(input logic [CP_W-1:0] cp, input int len, input int keep);
      logic [BYTE_W-1:0] seq [4];
      case (len)
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int k = 0; k < keep; k++) send_q.push_back(data_row(seq[k]));
   endtask

   // Mostly well-formed text, with malformed values, cut sequences and noise mixed in.
   task automatic add_random_stream(input int count);
      int start;
      int pick;
      int len;
      logic [CP_W-1:0] cp;
      start = send_q.size();
      while (send_q.size() - start < count) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (pick < 30) begin
            send_q.push_back(data_row(8'($urandom_range(0, 127))));
         end else if (pick < 70) begin
            push_encoded(pick_scalar(len), len, len);
         end else if (pick < 80) begin
            case ($urandom_range(0, 2))
               0: begin
                  if (len == 2) cp = CP_W'($urandom_range(0, MIN_TWO - 1));
                  else if (len == 3) cp = CP_W'($urandom_range(0, MIN_THREE - 1));
                  else cp = CP_W'($urandom_range(0, MIN_FOUR - 1));
               end
               1: begin
                  len = 3;
                  cp  = CP_W'($urandom_range(SURR_LO, SURR_HI));
               end
               default: begin
                  len = 4;
                  cp  = CP_W'($urandom_range(MAX_CP + 1, 21'h1FFFFF));
               end
            endcase
            push_encoded(cp, len, len);
         end else if (pick < 90) begin
            push_encoded(pick_scalar(len), len, $urandom_range(1, len - 1));
         end else begin
            send_q.push_back(data_row(8'($urandom_range(0, 255))));
         end
      end
   endtask

   task automatic wait_sent();
      while (send_q.size() != 0 || req_push) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   // Sender: take the accepted beat, predict its results, offer the next byte.
   always @(posedge clock) begin : sender
      cp_result_type r;
      if (reset) begin
         seq_need = 2'd0;
         seq_held = 2'd0;
         seq_acc  = '0;
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            decode_byte(send_q[0].data);
            if (send_q[0].known) begin
               for (int i = 0; i < int'(send_q[0].n_res); i++) begin
                  r.cp   = send_q[0].cp;
                  r.bad  = send_q[0].bad;
                  r.last = (i == int'(send_q[0].n_res) - 1);
                  expected_q.push_back(r);
               end
            end else begin
               foreach (byte_results[j]) expected_q.push_back(byte_results[j]);
            end
            void'(send_q.pop_front());
            bytes_sent++;
         end
         if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_push    <= 1'b1;
            req_byte_in <= send_q[0].data;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: check each accepted beat against the oldest expected code point.
   always @(posedge clock) begin : receiver
      cp_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (rsp_malformed) replacements_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result cp=%h", rsp_code_point));
         end else begin
            want = expected_q.pop_front();
            if (rsp_code_point !== want.cp)
               report($sformatf("code_point %h, want %h", rsp_code_point, want.cp));
            if (rsp_malformed !== want.bad)
               report($sformatf("malformed %b, want %b (cp %h)", rsp_malformed, want.bad,
                                want.cp));
            if (rsp_last_of_run !== want.last)
               report($sformatf("last_of_run %b, want %b (cp %h)", rsp_last_of_run,
                                want.last, want.cp));
         end
      end
      rsp_pop <= !reset && !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_full) full_cycles++;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes, then random text: sender idles lightly, receiver heavily.
      send_idle_pct = 32;
      recv_idle_pct = 83;
      foreach (directed_rows[i]) send_q.push_back(directed_rows[i]);
      add_random_stream(135);
      wait_sent();
      wait_drained();

      // Swap the idling; the sender has paused until every result came back.
      send_idle_pct = 83;
      recv_idle_pct = 32;
      add_random_stream(135);
      wait_sent();
      wait_drained();

      // Full rate, with a long receiver hold-off at the start to back up the input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            hold_active = 1'b1;
            repeat (60) @(negedge clock);
            hold_active = 1'b0;
         end
      join_none
      add_random_stream(135);
      wait_sent();
      wait_drained();
      repeat (20) @(negedge clock);

      $display("covered %0d bytes: ASCII, 2/3/4-byte forms, overlong, surrogate, out of range,",
               bytes_sent);
      $display("cut sequences and noise; %0d code points (%0d replacements), full %0d cycles",
               results_seen, replacements_seen, full_cycles);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
